// ===== rtl/core/tcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

	localparam int OP_W         = 2;
	localparam int CODE_W       = 8;
	localparam int ATTR_W       = 8;
	localparam int CELL_W       = 16;
	localparam int READ_ROW_W   = 5;
	localparam int READ_COL_W   = 7;
	localparam int CURSOR_ROW_W = 5;
	localparam int CURSOR_COL_W = 7;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CODE_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcc_req_if import tcc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [CODE_W-1:0]     char_code;
	logic [READ_ROW_W-1:0] read_row;
	logic [READ_COL_W-1:0] read_col;

	modport source (output valid, operation, char_code, read_row, read_col, input ready);
	modport sink (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if import tcc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CELL_W-1:0]       cell_value;
	logic [CURSOR_ROW_W-1:0] cursor_row;
	logic [CURSOR_COL_W-1:0] cursor_col;

	modport source (output valid, cell_value, cursor_row, cursor_col, input ready);
	modport sink (input valid, cell_value, cursor_row, cursor_col, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll.sv =====
`timescale 1ns / 1ps
`default_nettype none

// character-cell text console with cursor and scrolling
// req channel: one transaction per command (put character, read cell, clear screen)
// rsp channel: exactly one transaction per command, carrying the read cell (zero
//   unless a read) and the cursor position after the command
// cfg channel: writes the attribute byte used for new cells, always ready
// the screen lives in one ROWS*COLUMNS x 16 ram with a registered read
// put character or newline without scroll, and unused commands: straight from idle to the done state
// read cell: an extra read state for the ram read between idle and done
// clear screen: a fill state writes all ROWS*COLUMNS cells, one ram write per cycle
// scroll: each line moves up one cell per cycle
//   through the ram read port, then the bottom line is filled with spaces
// after reset the cursor is home, the attribute is 0x07 and a clearing pass
//   writes space cells; req.ready stays low meanwhile
// the result sits in an output register; while rsp is stalled the next command
//   is still taken and runs, and its result waits until the register frees

module text_console_cursor_scroll import tcc_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic clk,
	input wire logic arst_n,
	tcc_req_if.sink   req,
	tcc_rsp_if.source rsp,
	tcc_cfg_if.sink   cfg
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_X  = (ROW_W > CURSOR_ROW_W) ? ROW_W : CURSOR_ROW_W;

	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] LINE_STEP   = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

	state_t state_q, state_d;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [ADDR_W-1:0] idx_q;
	logic              copy_vld_s1;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic              in_range_s1;
	logic [CELL_W-1:0] res_cell_q;

	logic                    out_valid_q;
	logic [CELL_W-1:0]       out_cell_q;
	logic [CURSOR_ROW_W-1:0] out_row_q;
	logic [CURSOR_COL_W-1:0] out_col_q;

	logic in_ready;
	logic accept;
	logic out_free;
	op_t  op;

	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic              is_newline;
	logic              line_adv;
	logic              row_over;
	logic              scroll;
	logic [ROW_W-1:0]  row_next;
	logic [COL_W-1:0]  col_next;
	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_cell_addr;
	logic [ADDR_W-1:0] cur_addr;
	logic [ROW_X-1:0]  row_ext;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	logic [CELL_W-1:0] fill_cell;

	assign op       = op_t'(req.operation);
	assign accept   = req.valid && in_ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_value = out_cell_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cursor_col = out_col_q;

	// cursor advance
	assign is_newline = (req.char_code == NEWLINE_CODE);
	assign col_inc    = {1'b0, col_q} + 1'b1;
	assign row_inc    = {1'b0, row_q} + 1'b1;
	assign row_over   = (row_inc == (ROW_W + 1)'(ROWS));
	assign line_adv   = is_newline || (col_inc == (COL_W + 1)'(COLUMNS));
	assign scroll     = line_adv && row_over;
	assign row_next   = line_adv ? (row_over ? LAST_ROW : row_inc[ROW_W-1:0]) : row_q;
	assign col_next   = line_adv ? '0 : col_inc[COL_W-1:0];

	assign rd_in_range  = (7'(req.read_row) < 7'(ROWS)) && (8'(req.read_col) < 8'(COLUMNS));
	assign rd_cell_addr = ADDR_W'(req.read_row * COLUMNS + req.read_col);
	assign cur_addr     = ADDR_W'(row_q * COLUMNS + col_q);
	assign row_ext      = ROW_X'(row_q);

	assign fill_cell = (state_q == ST_INIT) ? {RESET_ATTR, SPACE_CODE} : {attr_q, SPACE_CODE};

	tcc_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (idx_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUT:   state_d = scroll ? ST_SCROLL : ST_DONE;
						OP_READ:  state_d = ST_READ;
						OP_CLEAR: state_d = ST_FILL;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_SCROLL: begin
				if (idx_q == COPY_LAST) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!copy_vld_s1 && idx_q == LAST_CELL) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = fill_cell;
		ram_raddr = rd_cell_addr;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && op == OP_PUT && !is_newline) begin
					ram_we    = 1'b1;
					ram_waddr = cur_addr;
					ram_wdata = {attr_q, req.char_code};
				end
			end
			ST_SCROLL, ST_FILL, ST_INIT: begin
				ram_raddr = idx_q + LINE_STEP;
				if (copy_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = copy_addr_s1;
					ram_wdata = ram_rdata;
				end else if (state_q != ST_SCROLL) begin
					ram_we = 1'b1;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			idx_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			attr_q      <= RESET_ATTR;
			copy_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			copy_vld_s1 <= (state_q == ST_SCROLL);

			if (cfg.valid && cfg.ready) begin
				attr_q <= cfg.data;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (op == OP_PUT) begin
							row_q <= row_next;
							col_q <= col_next;
						end else if (op == OP_CLEAR) begin
							row_q <= '0;
							col_q <= '0;
						end
					end
				end
				ST_SCROLL: begin
					idx_q <= (idx_q == COPY_LAST) ? BOTTOM_BASE : idx_q + 1'b1;
				end
				ST_FILL, ST_INIT: begin
					if (!copy_vld_s1 && idx_q != LAST_CELL) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= idx_q;
		if (accept) begin
			res_cell_q  <= '0;
			in_range_s1 <= rd_in_range;
		end else if (state_q == ST_READ) begin
			res_cell_q <= in_range_s1 ? ram_rdata : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_cell_q <= res_cell_q;
			out_row_q  <= row_ext[CURSOR_ROW_W-1:0];
			out_col_q  <= CURSOR_COL_W'(col_q);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcc_checker import tcc_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    req_valid,
	input wire logic                    req_ready,
	input wire logic                    rsp_valid,
	input wire logic                    rsp_ready,
	input wire logic [CELL_W-1:0]       rsp_cell_value,
	input wire logic [CURSOR_ROW_W-1:0] rsp_cursor_row,
	input wire logic [CURSOR_COL_W-1:0] rsp_cursor_col
);

	// a command is taken only from idle, so the block is busy right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("req ready stayed high after a transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (8'(rsp_cursor_col) < 8'(COLUMNS)))
		else $error("cursor column beyond the line");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (7'(rsp_cursor_row) < 7'(ROWS)))
		else $error("cursor row beyond the screen");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		($stable(rsp_cell_value) && $stable(rsp_cursor_row) && $stable(rsp_cursor_col)))
		else $error("rsp payload changed while stalled");

endmodule

bind text_console_cursor_scroll tcc_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_cell_value(rsp.cell_value),
	.rsp_cursor_row(rsp.cursor_row),
	.rsp_cursor_col(rsp.cursor_col)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tcc_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	typedef struct packed {
		op_t                   op;
		logic [CODE_W-1:0]     code;
		logic [READ_ROW_W-1:0] row;
		logic [READ_COL_W-1:0] col;
	} console_cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0]       cell_val;
		logic [CURSOR_ROW_W-1:0] row;
		logic [CURSOR_COL_W-1:0] col;
	} console_view_t;

	logic clk;
	logic arst_n;

	tcc_req_if req_bus ();
	tcc_rsp_if rsp_bus ();
	tcc_cfg_if cfg_bus ();

	text_console_cursor_scroll #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	// shadow copy of the console
	logic [CELL_W-1:0] screen_mirror [CELLS];
	int                cur_row;
	int                cur_col;
	logic [ATTR_W-1:0] text_attr;

	console_cmd_t  pending_cmds [$];
	console_view_t expected_views [$];

	int   cmds_queued;
	int   cmds_taken;
	int   fail_count;
	logic cmd_fired;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic console_newline();
		int i;
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
				screen_mirror[i] = screen_mirror[i + COLUMNS];
			for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
				screen_mirror[i] = {text_attr, SPACE_CODE};
			cur_row = ROWS - 1;
		end
	endtask

	task automatic console_fill();
		int i;
		for (i = 0; i < CELLS; i++)
			screen_mirror[i] = {text_attr, SPACE_CODE};
	endtask

	task automatic console_apply(input console_cmd_t c);
		console_view_t v;
		v.cell_val = '0;
		case (c.op)
			OP_PUT: begin
				if (c.code == NEWLINE_CODE) begin
					console_newline();
				end else begin
					screen_mirror[cur_row * COLUMNS + cur_col] = {text_attr, c.code};
					cur_col++;
					if (cur_col >= COLUMNS)
						console_newline();
				end
			end
			OP_READ: begin
				if (c.row < ROWS && c.col < COLUMNS)
					v.cell_val = screen_mirror[c.row * COLUMNS + c.col];
			end
			OP_CLEAR: begin
				console_fill();
				cur_row = 0;
				cur_col = 0;
			end
			default: begin
			end
		endcase
		v.row = cur_row[CURSOR_ROW_W-1:0];
		v.col = cur_col[CURSOR_COL_W-1:0];
		expected_views.push_back(v);
	endtask

	function automatic int gap_len();
		int d;
		d = $urandom_range(0, 99);
		if (d < 70)
			return $urandom_range(1, 3);
		else if (d < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic console_cmd_t mk_cmd(input op_t op, input logic [CODE_W-1:0] code,
			input int row, input int col);
		console_cmd_t c;
		c.op   = op;
		c.code = code;
		c.row  = row[READ_ROW_W-1:0];
		c.col  = col[READ_COL_W-1:0];
		return c;
	endfunction

	function automatic console_cmd_t random_cmd();
		console_cmd_t c;
		int           d;
		c.code = CODE_W'($urandom_range(0, 255));
		c.row  = READ_ROW_W'($urandom_range(0, 31));
		c.col  = READ_COL_W'($urandom_range(0, 127));
		d = $urandom_range(0, 999);
		if (d < 620) begin
			c.op = OP_PUT;
			if ($urandom_range(0, 99) < 12)
				c.code = NEWLINE_CODE;
		end else if (d < 957) begin
			c.op = OP_READ;
			d = $urandom_range(0, 99);
			if (d < 25) begin
				c.row = READ_ROW_W'(ROWS - 1);
				c.col = READ_COL_W'($urandom_range(0, COLUMNS - 1));
			end else if (d < 85) begin
				c.row = READ_ROW_W'($urandom_range(0, ROWS - 1));
				c.col = READ_COL_W'($urandom_range(0, COLUMNS - 1));
			end
		end else if (d < 960) begin
			c.op = OP_CLEAR;
		end else begin
			c.op = OP_NONE;
		end
		return c;
	endfunction

	task automatic enqueue(input console_cmd_t c);
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	task automatic settle();
		do @(negedge clk);
		while (cmds_taken != cmds_queued || expected_views.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_attr(input logic [ATTR_W-1:0] a);
		@(negedge clk);
		cfg_bus.data  <= a;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk);
		while (!(cfg_bus.valid && cfg_bus.ready));
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// command driver
	console_cmd_t cur_cmd;
	logic         sending;
	int           gap_left;
	int           calm_tx;

	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (sending && cmd_fired)
				sending = 1'b0;
			cmd_fired = 1'b0;
			if (!sending) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					sending = 1'b1;
					if (calm_tx > 0) begin
						calm_tx--;
						gap_left = 0;
					end else begin
						gap_left = ($urandom_range(0, 99) < 40) ? gap_len() : 0;
						if ($urandom_range(0, 49) == 0)
							calm_tx = $urandom_range(30, 150);
					end
				end
			end
			req_bus.valid <= sending;
			if (sending) begin
				req_bus.operation <= cur_cmd.op;
				req_bus.char_code <= cur_cmd.code;
				req_bus.read_row  <= cur_cmd.row;
				req_bus.read_col  <= cur_cmd.col;
			end
		end
	end

	// result stalls
	int ready_hold;
	int calm_rx;

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
			if (calm_rx > 0) begin
				calm_rx--;
			end else begin
				if ($urandom_range(0, 99) < 15)
					ready_hold = gap_len();
				if ($urandom_range(0, 199) == 0)
					calm_rx = $urandom_range(50, 300);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		console_view_t got;
		console_view_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				text_attr = cfg_bus.data;
			if (req_bus.valid && req_bus.ready) begin
				console_apply(mk_cmd(op_t'(req_bus.operation), req_bus.char_code,
					int'(req_bus.read_row), int'(req_bus.read_col)));
				cmds_taken++;
				cmd_fired = 1'b1;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.cell_val = rsp_bus.cell_value;
				got.row      = rsp_bus.cursor_row;
				got.col      = rsp_bus.cursor_col;
				if (expected_views.size() == 0) begin
					$display("%0t unexpected transaction: cell %h row %0d col %0d",
						$time, got.cell_val, got.row, got.col);
					fail_count++;
				end else begin
					want = expected_views.pop_front();
					if (got.cell_val !== want.cell_val) begin
						$display("%0t cell_value expected %h actual %h", $time,
							want.cell_val, got.cell_val);
						fail_count++;
					end
					if (got.row !== want.row) begin
						$display("%0t cursor_row expected %0d actual %0d", $time, want.row, got.row);
						fail_count++;
					end
					if (got.col !== want.col) begin
						$display("%0t cursor_col expected %0d actual %0d", $time, want.col, got.col);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int p;
		int i;
		logic [ATTR_W-1:0] a;
		arst_n            = 1'b0;
		req_bus.valid     = 1'b0;
		req_bus.operation = OP_NONE;
		req_bus.char_code = '0;
		req_bus.read_row  = '0;
		req_bus.read_col  = '0;
		rsp_bus.ready     = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.data      = '0;
		sending           = 1'b0;
		cmd_fired         = 1'b0;
		gap_left          = 0;
		calm_tx           = 0;
		ready_hold        = 0;
		calm_rx           = 0;
		cmds_queued       = 0;
		cmds_taken        = 0;
		fail_count        = 0;
		text_attr         = RESET_ATTR;
		cur_row           = 0;
		cur_col           = 0;
		console_fill();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait out the clearing pass
		do @(posedge clk);
		while (req_bus.ready !== 1'b1);

		enqueue(mk_cmd(OP_READ, 8'h00, 0, 0));
		enqueue(mk_cmd(OP_READ, 8'hFF, ROWS - 1, COLUMNS - 1));
		enqueue(mk_cmd(OP_READ, 8'h00, 31, 127));
		enqueue(mk_cmd(OP_READ, 8'h00, ROWS, 0));
		enqueue(mk_cmd(OP_READ, 8'h00, 0, COLUMNS));
		enqueue(mk_cmd(OP_PUT, 8'h00, 31, 127));
		enqueue(mk_cmd(OP_PUT, 8'hFF, 0, 0));
		enqueue(mk_cmd(OP_PUT, 8'h41, 0, 0));
		enqueue(mk_cmd(OP_PUT, NEWLINE_CODE, 0, 0));
		enqueue(mk_cmd(OP_NONE, 8'hFF, 31, 127));
		enqueue(mk_cmd(OP_READ, 8'h00, 0, 0));
		enqueue(mk_cmd(OP_READ, 8'h00, 0, 1));
		enqueue(mk_cmd(OP_READ, 8'h00, 0, 2));
		enqueue(mk_cmd(OP_READ, 8'h00, 1, 0));
		settle();

		write_attr(8'hFF);
		enqueue(mk_cmd(OP_PUT, SPACE_CODE, 0, 0));
		enqueue(mk_cmd(OP_READ, 8'h00, 1, 0));
		enqueue(mk_cmd(OP_CLEAR, 8'hFF, 31, 127));
		enqueue(mk_cmd(OP_READ, 8'h00, 0, 0));
		enqueue(mk_cmd(OP_READ, 8'h00, ROWS - 1, COLUMNS - 1));
		enqueue(mk_cmd(OP_PUT, NEWLINE_CODE, 0, 0));
		enqueue(mk_cmd(OP_PUT, 8'h7F, 0, 0));
		enqueue(mk_cmd(OP_READ, 8'h00, 1, 0));
		settle();

		write_attr(8'h00);
		for (p = 0; p < 8; p++) begin
			if (p == 3 || p == 6)
				enqueue(mk_cmd(OP_CLEAR, 8'h00, 0, 0));
			for (i = 0; i < 230; i++)
				enqueue(random_cmd());
			settle();
			case (p)
				0: a = 8'hFF;
				1: a = 8'h0F;
				2: a = 8'hF0;
				default: a = ATTR_W'($urandom_range(0, 255));
			endcase
			write_attr(a);
		end
		enqueue(mk_cmd(OP_READ, 8'h00, ROWS - 1, 0));
		enqueue(mk_cmd(OP_PUT, NEWLINE_CODE, 0, 0));
		enqueue(mk_cmd(OP_READ, 8'h00, ROWS - 1, COLUMNS - 1));
		settle();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== text_console_cursor_scroll.f =====
rtl/core/tcc_pkg.sv
rtl/core/tcc_ifs.sv
rtl/core/tcc_ram.sv
rtl/core/text_console_cursor_scroll.sv
rtl/core/tcc_checker.sv
tb/testbench.sv
